FILE: rtl/rfrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrf_pkg
// shared codes and command/status types for the chord root finder
// ----------------------------------------------------------------------------
package rfrf_pkg;

  localparam logic [2:0] ST_FOUND  = 3'd0;
  localparam logic [2:0] ST_NEED   = 3'd1;
  localparam logic [2:0] ST_ORDER  = 3'd2;
  localparam logic [2:0] ST_EQUAL  = 3'd3;
  localparam logic [2:0] ST_NOROOT = 3'd4;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_VALUE = 1'b1;

  localparam logic [0:0] REG_TOLERANCE  = 1'b0;
  localparam logic [0:0] REG_ITER_LIMIT = 1'b1;

  localparam logic [30:0] TOL_RESET   = 31'd66;
  localparam logic [23:0] LIMIT_RESET = 24'd10000000;

  // controller to datapath
  typedef struct packed {
    logic load_start;  // latch start item into the working ends
    logic load_value;  // latch value item into the value register
    logic update_end;  // replace the end on the matching sign side
    logic chord_go;    // launch the chord division
    logic take_point;  // capture divider result as the chord point
    logic clr_count;
    logic inc_count;
  } rfrf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_order;
    logic start_equal;
    logic start_noroot;
    logic start_hi_tol;
    logic start_lo_tol;
    logic val_below;    // |f| < tol
    logic val_above;    // |f| > tol
    logic count_zero;
    logic count_at_lim;
    logic side_lo;      // f not same sign as hi value
    logic side_hi;      // f not same sign as lo value
    logic upd_equal;    // ends' values too close after update
    logic chord_done;
  } rfrf_sts_t;

endpackage

FILE: rtl/rfrf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrf_divider
// restoring divider, one quotient bit per cycle, 2W/W with saturation
// ----------------------------------------------------------------------------
module rfrf_divider #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  logic [2*W-1:0] num,
  input  logic [W-1:0]   den,
  output logic           busy,
  output logic           done,
  output logic [W-1:0]   quo
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  lo;
  logic [CW-1:0] cnt;
  logic          sat;
  logic [W:0]    shifted;
  logic          sub_ok;

  assign shifted = {rem, lo[W-1]};
  assign sub_ok  = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rem  <= num[2*W-1:W];
        lo   <= num[W-1:0];
        quo  <= '0;
        sat  <= num[2*W-1:W] >= den;
        cnt  <= CW'(W);
        busy <= 1'b1;
      end else if (busy) begin
        if (sub_ok) begin
          rem <= W'(shifted - {1'b0, den});
        end else begin
          rem <= shifted[W-1:0];
        end
        lo  <= {lo[W-2:0], 1'b0};
        // quotient saturates when the high half already reaches the divisor
        quo <= (cnt == CW'(1) && sat) ? '1 : {quo[W-2:0], sub_ok};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/rfrf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrf_datapath
// interval registers, tests, chord multiply and divide
// ----------------------------------------------------------------------------
module rfrf_datapath #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rfrf_pkg::rfrf_cmd_t  cmd,
  output rfrf_pkg::rfrf_sts_t  sts,
  input  logic [30:0]          tolerance,
  input  logic [23:0]          iteration_limit,
  input  logic [31:0]          in_a,
  input  logic [31:0]          in_b,
  input  logic [31:0]          in_fa,
  input  logic [31:0]          in_fb,
  input  logic [31:0]          in_f,
  output logic [31:0]          point,
  output logic [31:0]          start_a,
  output logic [31:0]          start_b,
  output logic [23:0]          iteration_count
);

  logic signed [W-1:0] lo_end, hi_end, lo_value, hi_value, chord_point, fval;
  logic signed [W-1:0] a_w, b_w, fa_w, fb_w;
  logic [W:0]          tol_w;

  function automatic logic signed [W-1:0] wrap(input logic [31:0] x);
    logic signed [63:0] e;
    e = 64'(signed'(x));
    return e[W-1:0];
  endfunction

  function automatic logic [W:0] mag(input logic signed [W-1:0] x);
    logic signed [W:0] e;
    e = (W+1)'(x);
    return e < 0 ? (W+1)'(-e) : (W+1)'(e);
  endfunction

  function automatic logic [W:0] adiff(input logic signed [W-1:0] y,
                                       input logic signed [W-1:0] x);
    logic signed [W+1:0] d;
    d = (W+2)'(y) - (W+2)'(x);
    return d < 0 ? (W+1)'(-d) : (W+1)'(d);
  endfunction

  function automatic logic ssn(input logic signed [W-1:0] x,
                               input logic signed [W-1:0] y);
    return (x > 0 && y > 0) || (x < 0 && y < 0);
  endfunction

  assign a_w   = wrap(in_a);
  assign b_w   = wrap(in_b);
  assign fa_w  = wrap(in_fa);
  assign fb_w  = wrap(in_fb);
  assign tol_w = (W >= 31) ? (W+1)'(tolerance) : ((tolerance >> W) != 0 ? '1 : (W+1)'(tolerance));

  // start tests straight off the input beat
  assign sts.start_order  = a_w > b_w;
  assign sts.start_equal  = adiff(fb_w, fa_w) < tol_w;
  assign sts.start_noroot = ssn(fa_w, fb_w);
  assign sts.start_hi_tol = mag(fb_w) < tol_w;
  assign sts.start_lo_tol = mag(fa_w) < tol_w;

  assign sts.val_below    = mag(fval) < tol_w;
  assign sts.val_above    = mag(fval) > tol_w;
  assign sts.count_zero   = iteration_count == '0;
  assign sts.count_at_lim = iteration_count >= iteration_limit;
  assign sts.side_lo      = !ssn(fval, hi_value);
  assign sts.side_hi      = !ssn(fval, lo_value);
  assign sts.upd_equal    = adiff(hi_value, lo_value) < tol_w;

  // chord: prepare, multiply (registered), divide, finish
  logic [W-1:0]   span, den, mfa;
  logic           zero_case, q_neg;
  logic [2*W-1:0] prod;
  logic [1:0]     phase;
  logic           div_go, div_busy, div_done;
  logic [W-1:0]   quo, qlim;
  logic [W:0]     den_full;

  assign span     = W'(hi_end) - W'(lo_end);
  assign den_full = adiff(hi_value, lo_value);
  assign qlim     = quo > span ? span : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= 2'd0;
      div_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      case (phase)
        2'd0: begin
          if (cmd.chord_go) begin
            phase <= 2'd1;
          end
        end
        2'd1: begin
          den       <= den_full[W-1:0];
          mfa       <= W'(mag(lo_value));
          zero_case <= (den_full == '0) || (lo_value == '0);
          q_neg     <= (lo_value < 0) != (hi_value < lo_value);
          phase     <= 2'd2;
        end
        2'd2: begin
          prod   <= (2*W)'(mfa) * (2*W)'(span);
          div_go <= 1'b1;
          phase  <= 2'd3;
        end
        default: begin
          if (div_done) begin
            phase <= 2'd0;
          end
        end
      endcase
    end
  end

  rfrf_divider #(.W(W)) u_div (
    .clk (clk), .rst (rst), .go (div_go), .num (prod),
    .den (zero_case ? W'(1) : den),
    .busy (div_busy), .done (div_done), .quo (quo)
  );

  assign sts.chord_done = div_done && !div_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_end <= '0; hi_end <= '0; lo_value <= '0; hi_value <= '0;
      chord_point <= '0; iteration_count <= '0;
    end else begin
      if (cmd.load_start) begin
        lo_end <= a_w; hi_end <= b_w; lo_value <= fa_w; hi_value <= fb_w;
      end
      if (cmd.load_value) begin
        fval <= wrap(in_f);
      end
      if (cmd.update_end) begin
        if (sts.side_lo) begin
          lo_end <= chord_point; lo_value <= fval;
        end else begin
          hi_end <= chord_point; hi_value <= fval;
        end
      end
      if (cmd.take_point) begin
        chord_point <= (zero_case || !q_neg || quo == '0) ? lo_end
                       : $signed(W'(lo_end) + qlim);
      end
      if (cmd.clr_count) begin
        iteration_count <= '0;
      end else if (cmd.inc_count) begin
        iteration_count <= iteration_count + 24'd1;
      end
    end
  end

  // ends found at once are reported as wrapped words
  assign point   = 32'(chord_point);
  assign start_a = 32'(a_w);
  assign start_b = 32'(b_w);

endmodule

FILE: rtl/rfrf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfrf_ctrl
// sequencer: decides each beat, runs the chord, drives the result register
// ----------------------------------------------------------------------------
module rfrf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  rfrf_pkg::rfrf_sts_t  sts,
  output rfrf_pkg::rfrf_cmd_t  cmd,
  input  logic [31:0]          point,
  input  logic [31:0]          start_a,
  input  logic [31:0]          start_b,
  input  logic [23:0]          iteration_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [31:0]          out_point,
  output logic [23:0]          out_iter
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VAL   = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_CHORD = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2:0] state;
  logic       searching;
  logic       chord_inc;
  logic       take;
  logic       searching_pulse;

  assign take     = in_valid && in_ready;
  // the chord result goes out via searching_pulse, registered from take_point; hold input off till then
  assign in_ready = (state == S_IDLE) && !out_valid && !searching_pulse;

  always_comb begin
    cmd = '0;
    cmd.load_start = take && in_cmd == rfrf_pkg::CMD_START;
    cmd.load_value = take && in_cmd == rfrf_pkg::CMD_VALUE;
    cmd.clr_count  = cmd.load_start;
    cmd.update_end = state == S_UPD && !sts.count_at_lim && sts.val_above
                     && (sts.side_lo || sts.side_hi);
    cmd.chord_go   = (state == S_CHORD) && !(chord_inc && sts.upd_equal);
    cmd.take_point = state == S_WAIT && sts.chord_done;
    cmd.inc_count  = cmd.take_point && chord_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      searching  <= 1'b0;
      out_valid  <= 1'b0;
      chord_inc  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take && in_cmd == rfrf_pkg::CMD_START) begin
            if (sts.start_order) begin
              out_status <= rfrf_pkg::ST_ORDER; out_point <= '0; out_iter <= '0;
              out_valid <= 1'b1; searching <= 1'b0;
            end else if (sts.start_equal) begin
              out_status <= rfrf_pkg::ST_EQUAL; out_point <= '0; out_iter <= '0;
              out_valid <= 1'b1; searching <= 1'b0;
            end else if (sts.start_noroot) begin
              out_status <= rfrf_pkg::ST_NOROOT; out_point <= '0; out_iter <= '0;
              out_valid <= 1'b1; searching <= 1'b0;
            end else if (sts.start_hi_tol) begin
              out_status <= rfrf_pkg::ST_FOUND; out_point <= start_b; out_iter <= '0;
              out_valid <= 1'b1; searching <= 1'b0;
            end else if (sts.start_lo_tol) begin
              out_status <= rfrf_pkg::ST_FOUND; out_point <= start_a; out_iter <= '0;
              out_valid <= 1'b1; searching <= 1'b0;
            end else begin
              chord_inc <= 1'b0;
              state     <= S_CHORD;
            end
          end else if (take) begin
            state <= S_VAL;
          end
        end
        S_VAL: begin
          state <= S_IDLE;
          if (!searching) begin
            out_status <= rfrf_pkg::ST_NOROOT; out_point <= '0; out_iter <= '0;
            out_valid <= 1'b1;
          end else if (sts.count_zero && sts.val_below) begin
            out_status <= rfrf_pkg::ST_FOUND; out_point <= point; out_iter <= '0;
            out_valid <= 1'b1; searching <= 1'b0;
          end else if (sts.val_above && !sts.count_at_lim) begin
            if (sts.side_lo || sts.side_hi) begin
              state <= S_UPD;
            end else begin
              out_status <= rfrf_pkg::ST_NOROOT; out_point <= '0; out_iter <= '0;
              out_valid <= 1'b1; searching <= 1'b0;
            end
          end else if (sts.count_at_lim) begin
            out_status <= rfrf_pkg::ST_NOROOT; out_point <= '0; out_iter <= '0;
            out_valid <= 1'b1; searching <= 1'b0;
          end else begin
            out_status <= rfrf_pkg::ST_FOUND; out_point <= point;
            out_iter <= iteration_count; out_valid <= 1'b1; searching <= 1'b0;
          end
        end
        S_UPD: begin
          // ends were replaced this cycle, closeness test next
          state <= S_CHORD;
          chord_inc <= 1'b1;
        end
        S_CHORD: begin
          if (chord_inc && sts.upd_equal) begin
            out_status <= rfrf_pkg::ST_EQUAL; out_point <= '0; out_iter <= '0;
            out_valid <= 1'b1; searching <= 1'b0; state <= S_IDLE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (sts.chord_done) begin
            state     <= S_IDLE;
            searching <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      // result emitted on searching_pulse, which is registered from take_point
      if (state == S_IDLE && searching_pulse) begin
        out_status <= rfrf_pkg::ST_NEED; out_point <= point;
        out_iter <= '0; out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      searching_pulse <= 1'b0;
    end else begin
      searching_pulse <= cmd.take_point;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(in_ready && state != S_IDLE))
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst) cmd.take_point |=> state == S_IDLE)
    else $error("chord finish not back to idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_VAL) |-> $past(cmd.load_value))
    else $error("value state without value beat");

endmodule

FILE: rtl/regula_falsi_root_finder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regula_falsi_root_finder_top
// chord root finder over an outside function evaluator
// ----------------------------------------------------------------------------
// one item at a time: the next beat is taken once the result beat has gone.
// errors and immediate finds put out their result without the divider; a chord
// point, after a start beat or after a value beat that moves an end, waits
// for the one-bit-a-cycle divider forming fa*(b-a)/(fb-fa)
module regula_falsi_root_finder_top #(
  parameter int WORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,  // left_end, right_end, value_left, value_right,
                                 // value_at_point
  input  logic         s_tuser,  // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // status, point, iterations, 5 zero bits
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [30:0] tolerance;
  logic [23:0] iteration_limit;
  rfrf_pkg::rfrf_cmd_t cmd;
  rfrf_pkg::rfrf_sts_t sts;
  logic [31:0] point, sa, sb;
  logic [23:0] icount;
  logic [2:0]  o_st;
  logic [31:0] o_pt;
  logic [23:0] o_it;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance       <= rfrf_pkg::TOL_RESET;
      iteration_limit <= rfrf_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == rfrf_pkg::REG_TOLERANCE) begin
        tolerance <= cfg_data[30:0];
      end else begin
        iteration_limit <= cfg_data[23:0];
      end
    end
  end

  rfrf_datapath #(.W(WORD_BITS)) u_dp (
    .clk (clk), .rst (rst), .cmd (cmd), .sts (sts),
    .tolerance (tolerance), .iteration_limit (iteration_limit),
    .in_a (s_tdata[31:0]), .in_b (s_tdata[63:32]), .in_fa (s_tdata[95:64]),
    .in_fb (s_tdata[127:96]), .in_f (s_tdata[159:128]),
    .point (point), .start_a (sa), .start_b (sb), .iteration_count (icount)
  );

  rfrf_ctrl u_ctrl (
    .clk (clk), .rst (rst), .in_valid (s_tvalid), .in_ready (s_tready),
    .in_cmd (s_tuser), .sts (sts), .cmd (cmd), .point (point),
    .start_a (sa), .start_b (sb), .iteration_count (icount),
    .out_valid (m_tvalid), .out_ready (m_tready),
    .out_status (o_st), .out_point (o_pt), .out_iter (o_it)
  );

  assign m_tdata = {5'd0, o_it, o_pt, o_st};

endmodule

FILE: sim/regula_falsi_root_finder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regula_falsi_root_finder_top_test
// self-checking bench for the chord root finder
// ----------------------------------------------------------------------------
// a queue of start and value beats feeds a clocked driver; every accepted
// beat runs through a local chord predictor whose answers queue up and are
// checked field by field against each accepted output beat. the run walks
// through several tolerance and iteration limit settings and idling phases.
module regula_falsi_root_finder_top_test;

  typedef struct packed {
    logic        cmd;
    logic [31:0] left_end;
    logic [31:0] right_end;
    logic [31:0] value_left;
    logic [31:0] value_right;
    logic [31:0] value_at_point;
  } probe_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] point;
    logic [23:0] iterations;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = rfrf_pkg::REG_TOLERANCE;
  logic [31:0]  cfg_data = '0;

  regula_falsi_root_finder_top DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  longint      lo_end, hi_end, lo_val, hi_val, chord_pt;
  int unsigned iter_count;
  bit          searching;
  longint      tol = 64'(rfrf_pkg::TOL_RESET);
  int unsigned iter_limit = 32'(rfrf_pkg::LIMIT_RESET);

  probe_t  probe_q[$];
  answer_t answer_q[$];
  probe_t  in_flight;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      err_count = 0;
  int      quiet_cycles = 0;

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint chord_at(longint a, longint b, longint fa, longint fb);
    longint unsigned span, den, q;
    logic            q_neg;
    span = longint'(b - a);
    den  = mag(fb - fa);
    if (den == 0 || fa == 0) return a;
    q = longint'(mag(fa) * longint'(span)) / den;
    q_neg = (fa < 0) != (fb < fa);
    if (!q_neg || q == 0) return a;
    if (q > span) q = span;
    return a + longint'(q);
  endfunction

  function automatic bit same_sign(longint x, longint y);
    return (x > 0 && y > 0) || (x < 0 && y < 0);
  endfunction

  function automatic answer_t give_up(logic [2:0] st);
    searching = 0;
    return '{st, 32'd0, 24'd0};
  endfunction

  function automatic answer_t root_step(probe_t p);
    longint a, b, fa, fb, f;
    answer_t r;
    a  = longint'($signed(p.left_end));
    b  = longint'($signed(p.right_end));
    fa = longint'($signed(p.value_left));
    fb = longint'($signed(p.value_right));
    f  = longint'($signed(p.value_at_point));
    if (p.cmd == rfrf_pkg::CMD_START) begin
      if (a > b) return give_up(rfrf_pkg::ST_ORDER);
      if (mag(fb - fa) < tol) return give_up(rfrf_pkg::ST_EQUAL);
      if (same_sign(fa, fb)) return give_up(rfrf_pkg::ST_NOROOT);
      if (mag(fb) < tol) begin
        searching = 0;
        return '{rfrf_pkg::ST_FOUND, b[31:0], 24'd0};
      end
      if (mag(fa) < tol) begin
        searching = 0;
        return '{rfrf_pkg::ST_FOUND, a[31:0], 24'd0};
      end
      lo_end = a; hi_end = b; lo_val = fa; hi_val = fb;
      chord_pt = chord_at(a, b, fa, fb);
      iter_count = 0;
      searching = 1;
      return '{rfrf_pkg::ST_NEED, chord_pt[31:0], 24'd0};
    end
    if (!searching) return give_up(rfrf_pkg::ST_NOROOT);
    if (iter_count == 0 && mag(f) < tol) begin
      searching = 0;
      return '{rfrf_pkg::ST_FOUND, chord_pt[31:0], 24'd0};
    end
    if (mag(f) > tol && iter_count < iter_limit) begin
      if (!same_sign(f, hi_val)) begin
        lo_end = chord_pt; lo_val = f;
      end else if (!same_sign(f, lo_val)) begin
        hi_end = chord_pt; hi_val = f;
      end else begin
        return give_up(rfrf_pkg::ST_NOROOT);
      end
      if (mag(hi_val - lo_val) < tol) return give_up(rfrf_pkg::ST_EQUAL);
      chord_pt = chord_at(lo_end, hi_end, lo_val, hi_val);
      iter_count++;
      return '{rfrf_pkg::ST_NEED, chord_pt[31:0], 24'd0};
    end
    if (iter_count >= iter_limit) return give_up(rfrf_pkg::ST_NOROOT);
    searching = 0;
    r = '{rfrf_pkg::ST_FOUND, chord_pt[31:0], iter_count[23:0]};
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) answer_q.push_back(root_step(in_flight));
      if (!s_tvalid || s_tready) begin
        if (probe_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight <= probe_q[0];
          s_tuser   <= probe_q[0].cmd;
          s_tdata   <= {probe_q[0].value_at_point, probe_q[0].value_right,
                        probe_q[0].value_left, probe_q[0].right_end, probe_q[0].left_end};
          s_tvalid  <= 1'b1;
          void'(probe_q.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    err_count++;
  endtask

  // monitor
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected beat status", m_tdata[2:0], -1);
        end else begin
          want = answer_q.pop_front();
          if (m_tdata[2:0] !== want.status)
            report_mismatch("status", m_tdata[2:0], want.status);
          if (m_tdata[34:3] !== want.point)
            report_mismatch("point", $signed(m_tdata[34:3]), $signed(want.point));
          if (m_tdata[58:35] !== want.iterations)
            report_mismatch("iterations", m_tdata[58:35], want.iterations);
        end
      end
    end
  end

  // watchdog on handshake inactivity
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
        rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] any_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(2000) - 1000;
      2: return $urandom_range(1 << 20) - (1 << 19);
      default: return 32'(tol + $urandom_range(3) - 1);
    endcase
  endfunction

  task automatic push(logic cmd, logic [31:0] a, b, fa, fb, fv);
    probe_q.push_back('{cmd, a, b, fa, fb, fv});
  endtask

  task automatic push_value(logic [31:0] fv);
    push(rfrf_pkg::CMD_VALUE, $urandom, $urandom, $urandom, $urandom, fv);
  endtask

  // well formed search: ordered ends, opposite signs, then value beats
  task automatic push_search();
    logic [31:0] a, b, t, fa, fb;
    int n;
    a = any_value(); b = any_value();
    if ($signed(a) > $signed(b)) begin
      t = a; a = b; b = t;
    end
    fa = $urandom_range(1 << $urandom_range(30)) + tol[30:0];
    fb = -($urandom_range(1 << $urandom_range(30)) + tol[30:0]);
    if ($urandom_range(1)) begin
      t = fa; fa = fb; fb = t;
    end
    push(rfrf_pkg::CMD_START, a, b, fa, fb, $urandom);
    n = $urandom_range(8);
    repeat (n) begin
      case ($urandom_range(5))
        0: push_value($urandom_range(1) ? tol[31:0] : -tol[31:0]);
        1: push_value(tol > 0 ? $urandom_range(32'(tol - 1)) : 32'd0);
        2: push_value($urandom);
        default: push_value(any_value());
      endcase
    end
  endtask

  task automatic settle();
    wait (probe_q.size() == 0 && answer_q.size() == 0 && !s_tvalid);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rfrf_pkg::REG_TOLERANCE) tol = 64'(data[30:0]);
    else iter_limit = 32'(data[23:0]);
  endtask

  localparam int SEGMENTS = 8;
  int          seg_tol[SEGMENTS]   = '{66, 0, 2147483647, 1000, 0, 66, 1, 65536};
  int unsigned seg_limit[SEGMENTS] = '{10000000, 1, 3, 10000000, 2, 5, 10000000, 1};

  initial begin
    int seg;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every status, start while searching, value while idle
    push(rfrf_pkg::CMD_START, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
         '1);
    push_value(32'h7fff_ffff);
    push_value(32'h8000_0000);
    push(rfrf_pkg::CMD_START, 32'd10, 32'd5, 32'd100, -32'd100, '0);
    push(rfrf_pkg::CMD_START, 32'd0, 32'd5, 32'd100, 32'd130, '0);
    push(rfrf_pkg::CMD_START, 32'd0, 32'd5, 32'd1000, 32'd2000, '0);
    push(rfrf_pkg::CMD_START, 32'd0, 32'd5, 32'd1000, 32'd3, '0);
    push(rfrf_pkg::CMD_START, 32'd0, 32'd5, -32'd7, 32'd3000, '0);
    push_value(32'd50);
    push(rfrf_pkg::CMD_START, 32'h0, 32'h5_0000, -32'h1_0000, 32'h4_0000, '0);
    push(rfrf_pkg::CMD_START, 32'h0, 32'h5_0000, -32'h1_0000, 32'h4_0000, '0);
    push_value(32'd66);
    push(rfrf_pkg::CMD_START, 32'h0, 32'h5_0000, -32'h1_0000, 32'h4_0000, '0);
    push_value(32'h100);
    push_value(-32'd66);
    push(rfrf_pkg::CMD_START, 32'h0, 32'h5_0000, 32'h1_0000, -32'h4_0000, '0);
    push_value(32'd10);
    settle();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      write_reg(rfrf_pkg::REG_TOLERANCE, seg_tol[seg]);
      write_reg(rfrf_pkg::REG_ITER_LIMIT, seg_limit[seg]);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      // zero divisor and limit cases only show with these settings
      push(rfrf_pkg::CMD_START, 32'd3, 32'd9, 32'd0, 32'd0, '0);
      push_value(32'h2_0000);
      push_value(-32'h2_0000);
      push_value(32'h3_0000);
      for (int k = 0; k < 210; ) begin
        int before_cnt;
        before_cnt = probe_q.size();
        case ($urandom_range(9))
          0: push($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom);
          1: push_value(any_value());
          default: push_search();
        endcase
        k += probe_q.size() - before_cnt;
        wait (probe_q.size() < 16);
      end
      settle();
    end

    if (err_count == 0 && answer_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
